// ----- rtl/cube_direction_to_texel_address_unit_macros.svh -----
// Assertion macros shared by the checker of the cube direction to texel address unit.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef CUBE_DIRECTION_TO_TEXEL_ADDRESS_UNIT_MACROS_SVH
`define CUBE_DIRECTION_TO_TEXEL_ADDRESS_UNIT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that must also hold while reset is applied.
`define CDT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cdt_pkg.sv -----
// Package of the cube direction to texel address unit: payload types and constants.
// Used by every RTL file of the block; depends on nothing.
`default_nettype none

package cdt_pkg;

  localparam int DIR_W        = 16;
  localparam int QUOT_BITS    = 16;
  localparam int SIZE_W       = 11;
  localparam int TEXEL_W      = 10;
  localparam int OFFSET_W     = 23;
  localparam int MAX_FACE_SIZE = 1024;
  localparam int NUM_CELLS    = QUOT_BITS;

  // Half of one in face coordinates with 16 fraction bits.
  localparam logic [16:0] COORD_HALF = 17'd32768;

  // Face codes.
  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  // Register indexes on the configuration port.
  localparam logic REG_FACE_WIDTH  = 1'b0;
  localparam logic REG_FACE_HEIGHT = 1'b1;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
  } dir_t;

  typedef struct packed {
    logic [2:0]          face;
    logic [TEXEL_W-1:0]  texel_x;
    logic [TEXEL_W-1:0]  texel_y;
    logic [OFFSET_W-1:0] texel_offset;
  } tex_t;

  // Work carried along the divider chain: two partial remainders and quotients.
  typedef struct packed {
    logic [2:0]           face;
    logic                 zero;
    logic                 sign_a;
    logic                 sign_b;
    logic [DIR_W-1:0]     major;
    logic [DIR_W:0]       rem_a;
    logic [DIR_W:0]       rem_b;
    logic [QUOT_BITS-1:0] quot_a;
    logic [QUOT_BITS-1:0] quot_b;
  } work_t;

  // Effective face size: zero reads as one, large values saturate.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
    logic [SIZE_W-1:0] s;
    s = raw;
    if (raw == '0) s = SIZE_W'(1);
    else if (raw > SIZE_W'(MAX_FACE_SIZE)) s = SIZE_W'(MAX_FACE_SIZE);
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cube_direction_to_texel_address_unit.sv -----
// Top level of the cube direction to texel address unit.
// Depends on cdt_pkg, cdt_cell and cdt_back.
//
//   channel   handshake             payload      role
//   dir       dir_valid/dir_stall   cdt_pkg::dir_t  direction in
//   tex       tex_valid/tex_stall   cdt_pkg::tex_t  face, texel, offset out
//   config    APB psel/penable      pwdata       face_width @0, face_height @4
//
// One transaction is accepted every cycle while dir is not stalled; each result reaches
// tex after its transaction has passed 19 register stages: face selection (loaded
// at the accepting edge), 16 cells of the divider chain, two back-end stages.
// Reset (synchronous rst) empties every stage and sets both face sizes to 256.
// A stall on tex holds only the stages that are full; bubbles close up, so dir
// is stalled only when the whole chain is occupied.
`default_nettype none

module cube_direction_to_texel_address_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           dir_valid,
  output logic                dir_stall,
  input  wire cdt_pkg::dir_t  dir,
  output logic                tex_valid,
  input  wire logic           tex_stall,
  output cdt_pkg::tex_t       tex,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import cdt_pkg::*;

  logic [SIZE_W-1:0] face_width;
  logic [SIZE_W-1:0] face_height;
  logic [SIZE_W-1:0] width;
  logic [SIZE_W-1:0] height;

  logic [DIR_W-1:0]  ax;
  logic [DIR_W-1:0]  ay;
  logic [DIR_W-1:0]  az;
  logic [DIR_W-1:0]  major;
  logic [2:0]        face;
  logic [DIR_W-1:0]  src_a;
  logic [DIR_W-1:0]  src_b;
  logic              neg_a;
  logic              neg_b;
  logic [DIR_W-1:0]  mag_a;
  logic [DIR_W-1:0]  mag_b;
  work_t             front_next;
  work_t             front_work;
  logic              front_valid;
  logic              front_ready;

  logic              cell_valid [NUM_CELLS+1];
  work_t             cell_work  [NUM_CELLS+1];
  logic              cell_ready [NUM_CELLS+1];

  // Configuration registers; bit 2 of the address selects the register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      face_width  <= SIZE_W'(256);
      face_height <= SIZE_W'(256);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_FACE_WIDTH) face_width <= pwdata[SIZE_W-1:0];
      else                            face_height <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_FACE_WIDTH) prdata = {{(32-SIZE_W){1'b0}}, face_width};
    else                            prdata = {{(32-SIZE_W){1'b0}}, face_height};
  end

  assign width  = eff_size(face_width);
  assign height = eff_size(face_height);

  // Face selection: largest magnitude wins, ties go to the lower face.
  always_comb begin
    ax    = dir.dir_x[DIR_W-1] ? DIR_W'(-dir.dir_x) : DIR_W'(dir.dir_x);
    ay    = dir.dir_y[DIR_W-1] ? DIR_W'(-dir.dir_y) : DIR_W'(dir.dir_y);
    az    = dir.dir_z[DIR_W-1] ? DIR_W'(-dir.dir_z) : DIR_W'(dir.dir_z);
    major = ax;
    face  = dir.dir_x[DIR_W-1] ? FACE_NX : FACE_PX;
    if (ay > major) begin
      major = ay;
      face  = dir.dir_y[DIR_W-1] ? FACE_NY : FACE_PY;
    end
    if (az > major) begin
      major = az;
      face  = dir.dir_z[DIR_W-1] ? FACE_NZ : FACE_PZ;
    end
  end

  // Per-face choice of the two minor components and their remapping signs.
  always_comb begin
    unique case (face) inside
      FACE_PX: begin
        src_a = dir.dir_z; neg_a = 1'b1; src_b = dir.dir_y; neg_b = 1'b1;
      end
      FACE_NX: begin
        src_a = dir.dir_z; neg_a = 1'b0; src_b = dir.dir_y; neg_b = 1'b1;
      end
      FACE_PY, FACE_NY: begin
        src_a = dir.dir_x; neg_a = 1'b0; src_b = dir.dir_z; neg_b = 1'b0;
      end
      FACE_PZ: begin
        src_a = dir.dir_x; neg_a = 1'b0; src_b = dir.dir_y; neg_b = 1'b1;
      end
      default: begin
        src_a = dir.dir_x; neg_a = 1'b1; src_b = dir.dir_y; neg_b = 1'b1;
      end
    endcase
    mag_a = src_a[DIR_W-1] ? DIR_W'(-src_a) : src_a;
    mag_b = src_b[DIR_W-1] ? DIR_W'(-src_b) : src_b;
    front_next.face   = face;
    front_next.zero   = (major == '0);
    front_next.sign_a = src_a[DIR_W-1] ^ neg_a;
    front_next.sign_b = src_b[DIR_W-1] ^ neg_b;
    front_next.major  = major;
    front_next.rem_a  = {1'b0, mag_a};
    front_next.rem_b  = {1'b0, mag_b};
    front_next.quot_a = '0;
    front_next.quot_b = '0;
  end

  assign front_ready = !front_valid || cell_ready[0];
  assign dir_stall   = !front_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (front_ready) begin
      front_valid <= dir_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_ready) begin
      front_work <= front_next;
    end
  end

  assign cell_valid[0] = front_valid;
  assign cell_work[0]  = front_work;

  // Divider chain: one quotient bit per cell.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    cdt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .prev_valid (cell_valid[i]),
      .prev_work  (cell_work[i]),
      .prev_ready (cell_ready[i]),
      .valid      (cell_valid[i+1]),
      .work       (cell_work[i+1]),
      .next_ready (cell_ready[i+1])
    );
  end

  cdt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .width      (width),
    .height     (height),
    .prev_valid (cell_valid[NUM_CELLS]),
    .prev_work  (cell_work[NUM_CELLS]),
    .prev_ready (cell_ready[NUM_CELLS]),
    .tex_valid  (tex_valid),
    .tex        (tex),
    .tex_stall  (tex_stall)
  );

endmodule

`default_nettype wire

// ----- rtl/cdt_cell.sv -----
// One cell of the divider chain: a restoring step on both face coordinates.
// Depends on cdt_pkg.
`default_nettype none

module cdt_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          prev_valid,
  input  wire cdt_pkg::work_t prev_work,
  output logic               prev_ready,
  output logic               valid,
  output cdt_pkg::work_t     work,
  input  wire logic          next_ready
);
  import cdt_pkg::*;

  logic             bit_a;
  logic             bit_b;
  logic [DIR_W:0]   diff_a;
  logic [DIR_W:0]   diff_b;
  work_t            work_next;

  // Compare and subtract, then shift the remainder for the next cell.
  always_comb begin
    bit_a  = prev_work.rem_a >= {1'b0, prev_work.major};
    bit_b  = prev_work.rem_b >= {1'b0, prev_work.major};
    diff_a = bit_a ? prev_work.rem_a - {1'b0, prev_work.major} : prev_work.rem_a;
    diff_b = bit_b ? prev_work.rem_b - {1'b0, prev_work.major} : prev_work.rem_b;
    work_next        = prev_work;
    work_next.rem_a  = {diff_a[DIR_W-1:0], 1'b0};
    work_next.rem_b  = {diff_b[DIR_W-1:0], 1'b0};
    work_next.quot_a = {prev_work.quot_a[QUOT_BITS-2:0], bit_a};
    work_next.quot_b = {prev_work.quot_b[QUOT_BITS-2:0], bit_b};
  end

  assign prev_ready = !valid || next_ready;

  // The cell loads whenever its slot is free or drains this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (prev_ready) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prev_ready) begin
      work <= work_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cdt_back.sv -----
// Back end: texel coordinates from the quotients, then the strip offset.
// Depends on cdt_pkg.
`default_nettype none

module cdt_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [cdt_pkg::SIZE_W-1:0]  width,
  input  wire logic [cdt_pkg::SIZE_W-1:0]  height,
  input  wire logic                        prev_valid,
  input  wire cdt_pkg::work_t              prev_work,
  output logic                             prev_ready,
  output logic                             tex_valid,
  output cdt_pkg::tex_t                    tex,
  input  wire logic                        tex_stall
);
  import cdt_pkg::*;

  logic [QUOT_BITS-1:0] qa;
  logic [QUOT_BITS-1:0] qb;
  logic [16:0]          pos_a;
  logic [16:0]          pos_b;
  logic [27:0]          prod_a;
  logic [27:0]          prod_b;
  logic                 mid_valid;
  logic                 mid_ready;
  logic [2:0]           mid_face;
  logic [TEXEL_W-1:0]   mid_tx;
  logic [TEXEL_W-1:0]   mid_ty;
  logic [12:0]          row_face;
  logic [23:0]          offset_full;
  logic                 out_ready;
  tex_t                 tex_next;

  // Signed coordinate shifted by one half, scaled by size minus one, rounded.
  always_comb begin
    qa     = prev_work.zero ? '0 : prev_work.quot_a;
    qb     = prev_work.zero ? '0 : prev_work.quot_b;
    pos_a  = prev_work.sign_a ? COORD_HALF - {1'b0, qa} : COORD_HALF + {1'b0, qa};
    pos_b  = prev_work.sign_b ? COORD_HALF - {1'b0, qb} : COORD_HALF + {1'b0, qb};
    prod_a = 28'(pos_a) * 28'(width - SIZE_W'(1)) + 28'(COORD_HALF);
    prod_b = 28'(pos_b) * 28'(height - SIZE_W'(1)) + 28'(COORD_HALF);
  end

  assign out_ready  = !tex_valid || !tex_stall;
  assign mid_ready  = !mid_valid || out_ready;
  assign prev_ready = mid_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_ready) begin
      mid_valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_ready) begin
      mid_face <= prev_work.face;
      mid_tx   <= prod_a[16 +: TEXEL_W];
      mid_ty   <= prod_b[16 +: TEXEL_W];
    end
  end

  // Strip offset: width * (face + 6 * row) + column.
  always_comb begin
    row_face    = 13'(mid_ty) * 13'd6 + 13'(mid_face);
    offset_full = 24'(width) * 24'(row_face) + 24'(mid_tx);
    tex_next.face         = mid_face;
    tex_next.texel_x      = mid_tx;
    tex_next.texel_y      = mid_ty;
    tex_next.texel_offset = offset_full[OFFSET_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_valid <= 1'b0;
    end else if (out_ready) begin
      tex_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      tex <= tex_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cdt_checker.sv -----
// Port-level checker of the cube direction to texel address unit, bound to the top.
// Depends on cdt_pkg and the assertion macro header.
`default_nettype none
`include "cube_direction_to_texel_address_unit_macros.svh"

module cdt_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          dir_valid,
  input wire logic          dir_stall,
  input wire logic          tex_valid,
  input wire logic          tex_stall,
  input wire cdt_pkg::tex_t tex
);
  import cdt_pkg::*;

  // A stalled result holds its payload.
  `CDT_ASSERT(a_tex_hold, tex_valid && tex_stall |=> tex_valid && $stable(tex), "tex changed while stalled")

  // The input side only backs up when the output is blocked.
  `CDT_ASSERT(a_stall_cause, dir_stall |-> tex_valid && tex_stall, "dir stalled without tex stall")

  // Only the six faces appear.
  `CDT_ASSERT(a_face_range, tex_valid |-> tex.face <= FACE_NZ, "face code out of range")

  // Reset empties the output.
  `CDT_ASSERT_ALWAYS(a_reset_empty, rst |=> !tex_valid, "tex valid right after reset")

endmodule

bind cube_direction_to_texel_address_unit cdt_checker u_cdt_checker (.*);

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench of cube_direction_to_texel_address_unit.
// Drives random and directed directions, predicts face/texel/offset, checks results.
// Depends on cdt_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb;
  import cdt_pkg::*;

  logic        clk;
  logic        rst;
  logic        dir_valid;
  logic        dir_stall;
  dir_t        dir;
  logic        tex_valid;
  logic        tex_stall;
  tex_t        tex;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cube_direction_to_texel_address_unit dut (.*);

  // Predictor copy of the face size registers.
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;

  dir_t pending_dirs[$];
  tex_t expected_texels[$];
  int   mismatches;
  int   checked;
  int   cycles;
  bit   calm;
  bit   drain_hold;

  function automatic longint face_ratio(longint c, longint major);
    longint mag;
    if (major == 0) return 0;
    mag = (c < 0) ? -c : c;
    mag = (mag << 16) / (2 * major);
    return (c < 0) ? -mag : mag;
  endfunction

  function automatic longint to_texel(longint coord, longint size);
    if (coord < -32768) coord = -32768;
    if (coord > 32768) coord = 32768;
    return ((coord + 32768) * (size - 1) + 32768) >>> 16;
  endfunction

  function automatic longint size_of(logic [SIZE_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_FACE_SIZE) return MAX_FACE_SIZE;
    return raw;
  endfunction

  function automatic tex_t predict_texel(dir_t d);
    longint x, y, z, ax, ay, az, major, rx, ry, rz, a, b, w, h, tx, ty, off;
    logic [2:0] f;
    tex_t t;
    x = d.dir_x;
    y = d.dir_y;
    z = d.dir_z;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    major = ax;
    f = (x < 0) ? FACE_NX : FACE_PX;
    if (ay > major) begin
      major = ay;
      f = (y < 0) ? FACE_NY : FACE_PY;
    end
    if (az > major) begin
      major = az;
      f = (z < 0) ? FACE_NZ : FACE_PZ;
    end
    rx = face_ratio(x, major);
    ry = face_ratio(y, major);
    rz = face_ratio(z, major);
    case (f)
      FACE_PX: begin a = -rz; b = -ry; end
      FACE_NX: begin a = rz; b = -ry; end
      FACE_PY, FACE_NY: begin a = rx; b = rz; end
      FACE_PZ: begin a = rx; b = -ry; end
      default: begin a = -rx; b = -ry; end
    endcase
    w = size_of(width_reg);
    h = size_of(height_reg);
    tx = to_texel(a, w);
    ty = to_texel(b, h);
    off = w * f + ty * w * 6 + tx;
    t.face = f;
    t.texel_x = tx[TEXEL_W-1:0];
    t.texel_y = ty[TEXEL_W-1:0];
    t.texel_offset = off[OFFSET_W-1:0];
    return t;
  endfunction

  // Clock.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Direction driver: holds the payload while stalled, idles at random.
  always @(posedge clk) begin
    if (rst) begin
      dir_valid <= 1'b0;
    end else if (!dir_valid || !dir_stall) begin
      if (pending_dirs.size() > 0 && !drain_hold && (calm || $urandom_range(99) >= 12)) begin
        dir <= pending_dirs[0];
        expected_texels.push_back(predict_texel(pending_dirs[0]));
        void'(pending_dirs.pop_front());
        dir_valid <= 1'b1;
      end else begin
        dir_valid <= 1'b0;
      end
    end
  end

  // Result monitor and random stall on the output side.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      tex_stall <= 1'b0;
    end else begin
      tex_stall <= !calm && ($urandom_range(99) < 12);
      if (tex_valid && !tex_stall) begin
        if (expected_texels.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected result %p", tex);
        end else begin
          if (tex !== expected_texels[0]) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", expected_texels[0], tex);
          end
          void'(expected_texels.pop_front());
          checked = checked + 1;
        end
      end
    end
  end

  // Register write through the APB port.
  task automatic write_reg(logic idx, logic [SIZE_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_FACE_WIDTH) width_reg = value;
    else height_reg = value;
  endtask

  task automatic wait_idle();
    while (pending_dirs.size() > 0 || expected_texels.size() > 0 || dir_valid)
      @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'(-16384);
      1: return 16'd16384;
      2: return 16'($urandom_range(65535));
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  task automatic queue_dir(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    dir_t d;
    d.dir_x = x;
    d.dir_y = y;
    d.dir_z = z;
    pending_dirs.push_back(d);
  endtask

  task automatic queue_random(int n);
    repeat (n) queue_dir(rand_comp(), rand_comp(), rand_comp());
  endtask

  // Watchdog.
  always @(posedge clk) begin
    if (cycles > 200000) begin
      $display("FAIL cube_direction_to_texel_address_unit");
      $finish;
    end
  end

  initial begin
    logic [SIZE_W-1:0] widths[6];
    logic [SIZE_W-1:0] heights[6];
    widths = '{11'd256, 11'd1, 11'd1024, 11'd0, 11'd2047, 11'd37};
    heights = '{11'd256, 11'd1024, 11'd1, 11'd1500, 11'd0, 11'd613};
    rst = 1'b1;
    dir_valid = 1'b0;
    dir = '0;
    tex_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    width_reg = 11'd256;
    height_reg = 11'd256;
    mismatches = 0;
    checked = 0;
    cycles = 0;
    calm = 1'b0;
    drain_hold = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: each face, ties, zero vector, extremes, out-of-range components.
    queue_dir(16'd0, 16'd0, 16'd0);
    queue_dir(16'd16384, 16'd0, 16'd0);
    queue_dir(-16'd16384, 16'd0, 16'd0);
    queue_dir(16'd0, 16'd16384, 16'd0);
    queue_dir(16'd0, -16'd16384, 16'd0);
    queue_dir(16'd0, 16'd0, 16'd16384);
    queue_dir(16'd0, 16'd0, -16'd16384);
    queue_dir(16'd100, 16'd100, 16'd100);
    queue_dir(-16'd100, -16'd100, -16'd100);
    queue_dir(16'd5, -16'd5, 16'd5);
    queue_dir(16'h8000, 16'h7FFF, 16'h8000);
    queue_dir(16'h7FFF, 16'h8000, 16'h0001);
    queue_dir(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_dir(16'h0001, 16'h0000, 16'hFFFF);
    queue_dir(16'd16384, -16'd16383, 16'd16383);
    queue_dir(16'd3, 16'd7, -16'd11);
    queue_dir(-16'd9000, 16'd12000, 16'd4000);
    queue_dir(16'h5555, 16'hAAAA, 16'h1234);

    foreach (widths[i]) begin
      wait_idle();
      write_reg(REG_FACE_WIDTH, widths[i]);
      write_reg(REG_FACE_HEIGHT, heights[i]);
      calm = (i == 2);
      queue_random(100);
      if (i == 4) begin
        // Sender pauses mid-phase until everything has drained.
        while (pending_dirs.size() > 50) @(posedge clk);
        drain_hold = 1'b1;
        while (expected_texels.size() > 0) @(posedge clk);
        drain_hold = 1'b0;
      end
    end
    wait_idle();

    $display("Checked %0d results over six face size settings with random stalls.", checked);
    if (mismatches == 0) begin
      $display("PASS cube_direction_to_texel_address_unit");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL cube_direction_to_texel_address_unit");
    end
    $finish;
  end
endmodule
